[design/grvc_pkg.sv]
// shared types and constants of the grid ray visibility caster
package grvc_pkg;

	localparam int unsigned FLAG_W  = 6;
	localparam int unsigned COORD_W = 7;

	// flag bit positions
	localparam int unsigned FLAG_OPEN  = 0;
	localparam int unsigned FLAG_NORTH = 1;
	localparam int unsigned FLAG_EAST  = 2;
	localparam int unsigned FLAG_SOUTH = 3;
	localparam int unsigned FLAG_WEST  = 4;
	localparam int unsigned FLAG_VIS   = 5;

	typedef logic [FLAG_W-1:0]  flags_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_CAST  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_CLR_FIRST,
		ST_CLR_RUN,
		ST_CLR_LAST,
		ST_C_CHECK,
		ST_C_NZ,
		ST_C_NX,
		ST_C_CELL,
		ST_DONE
	} state_t;

	// line stepper control and status
	typedef struct packed {
		logic load;
		logic advance;
	} bres_ctrl_t;

	typedef struct packed {
		coord_t x;
		coord_t z;
		logic   done;
	} bres_stat_t;

endpackage

[design/grvc_bres.sv]
// bresenham line stepper: error term, position and remaining step count
module grvc_bres (
	input  logic                  clk,
	input  grvc_pkg::bres_ctrl_t  ctrl,
	input  logic [5:0]            start_x,
	input  logic [5:0]            start_z,
	input  grvc_pkg::coord_t      end_x,
	input  grvc_pkg::coord_t      end_z,
	output grvc_pkg::bres_stat_t  stat
);

	grvc_pkg::coord_t   x_q, z_q, dx_q, dz_q;
	logic               sx_q, sz_q;
	logic signed [9:0]  err_q;
	logic signed [7:0]  iter_q;

	grvc_pkg::coord_t   x0, z0, ldx, ldz, lmax;
	logic               lsx, lsz;
	logic signed [10:0] e2, ndz, pdx;
	logic               step_x, step_z;
	logic signed [9:0]  err_nx;

	always_comb begin
		x0     = {1'b0, start_x};
		z0     = {1'b0, start_z};
		lsx    = x0 < end_x;
		lsz    = z0 < end_z;
		ldx    = lsx ? (end_x - x0) : (x0 - end_x);
		ldz    = lsz ? (end_z - z0) : (z0 - end_z);
		lmax   = (ldx > ldz) ? ldx : ldz;
		e2     = {err_q, 1'b0};
		ndz    = -$signed({4'b0000, dz_q});
		pdx    = $signed({4'b0000, dx_q});
		step_x = e2 > ndz;
		step_z = e2 < pdx;
		err_nx = err_q - (step_x ? $signed({3'b000, dz_q}) : 10'sd0)
			+ (step_z ? $signed({3'b000, dx_q}) : 10'sd0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q    <= x0;
			z_q    <= z0;
			dx_q   <= ldx;
			dz_q   <= ldz;
			sx_q   <= lsx;
			sz_q   <= lsz;
			err_q  <= $signed({3'b000, ldx}) - $signed({3'b000, ldz});
			iter_q <= $signed({1'b0, lmax});
		end else if (ctrl.advance) begin
			if (step_x) begin
				x_q <= sx_q ? (x_q + 7'd1) : (x_q - 7'd1);
			end
			if (step_z) begin
				z_q <= sz_q ? (z_q + 7'd1) : (z_q - 7'd1);
			end
			err_q  <= err_nx;
			iter_q <= iter_q - 8'sd1;
		end
	end

	assign stat.x    = x_q;
	assign stat.z    = z_q;
	assign stat.done = iter_q[7];

endmodule

[design/grid_ray_visibility_cast_unit.sv]
// top level of the grid ray visibility caster: sequencer, grid memory and result register
//
// holds a GRID_SIDE x GRID_SIDE grid of 6-bit cell flags (open, north/east/south/west
// closed, visible) in a single memory with one write and one registered read port.
// each request carries a command in s_tuser: write a cell, clear every visible mark,
// cast a ray, or read a cell; every request yields exactly one result on the master
// side. the block takes one request at a time and is not ready while it works, but it
// does take the next request while the previous result still waits in the output
// register. timing is set by the single read port of the grid memory, shared by all
// lookups through one address unit (row * GRID_SIDE + column). a cast reads the start
// cell and the cell of each straight step in turn; on a diagonal step the two axis
// neighbours are fetched one after another before the new cell itself. taking the
// request, seeing the walk end and loading the result each add a state of their own.
// the longest ray is a diagonal across all 64 cells at the default size. a clear of
// the visible marks is a read-modify-write sweep over the whole grid. a result that
// cannot leave the output register holds the block in its final state. after reset
// the block runs a clearing pass over all GRID_SIDE*GRID_SIDE cells with s_tready
// low before it takes its first request.
module grid_ray_visibility_cast_unit #(
	parameter int unsigned GRID_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // start_x[5:0], start_z[11:6], end_x[18:12],
	                               // end_z[25:19], write_flags[31:26]
	input  logic [1:0]  s_tuser,   // command[1:0]
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // read_flags[5:0], ray_blocked[6], stop_x[12:7],
	                               // stop_z[18:13], zero padding[23:19]
);

	localparam int unsigned    DEPTH     = GRID_SIDE * GRID_SIDE;
	localparam int unsigned    AW        = $clog2(DEPTH);
	localparam logic [8:0]     SIDE_LIM  = 9'(GRID_SIDE);
	localparam logic [16:0]    SIDE_MUL  = 17'(GRID_SIDE);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

	// request fields
	grvc_pkg::cmd_t    in_cmd;
	logic [5:0]        in_start_x, in_start_z;
	grvc_pkg::coord_t  in_end_x, in_end_z;
	grvc_pkg::flags_t  in_wflags;

	// sequencer
	grvc_pkg::state_t  state_q, state_nx;
	logic [AW-1:0]     cnt_q;      // sweep address
	logic [AW-1:0]     wr_q;       // sweep write-back address, one behind cnt_q

	// ray and result registers
	grvc_pkg::cmd_t    cmd_q;
	grvc_pkg::coord_t  lx_q, lz_q; // last accepted cell
	grvc_pkg::flags_t  cprev_q;    // flags of last accepted cell
	grvc_pkg::flags_t  nz_q;       // flags of the z neighbour on a diagonal step
	grvc_pkg::flags_t  rd_q;
	logic              blk_q;
	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;
	logic [23:0]       res_data;

	// grid memory
	grvc_pkg::flags_t  mem_q [DEPTH];
	grvc_pkg::flags_t  rdata_q;
	logic              rd_en, wr_en;
	logic [AW-1:0]     raddr, waddr;
	grvc_pkg::flags_t  wdata;
	logic              r_from_cnt, w_from_cnt, w_from_wr;

	// shared address unit
	grvc_pkg::coord_t  ax, az;
	logic [16:0]       addr_full;
	logic [AW-1:0]     coord_addr;

	// line stepper
	grvc_pkg::bres_ctrl_t bctl;
	grvc_pkg::bres_stat_t bstat;

	// decisions
	logic acc, in_ok, cur_ok, walk_end, out_free, rd_open;
	logic mv_x, mv_z, pos_x, pos_z, diag;
	logic a_hit, b_hit, c_hit, d_hit, straight_blk, diag_blk;
	grvc_pkg::flags_t  cell_vis, cell_novis;

	assign in_cmd     = grvc_pkg::cmd_t'(s_tuser);
	assign in_start_x = s_tdata[5:0];
	assign in_start_z = s_tdata[11:6];
	assign in_end_x   = s_tdata[18:12];
	assign in_end_z   = s_tdata[25:19];
	assign in_wflags  = s_tdata[31:26];

	grvc_bres u_bres (
		.clk     (clk),
		.ctrl    (bctl),
		.start_x (in_start_x),
		.start_z (in_start_z),
		.end_x   (in_end_x),
		.end_z   (in_end_z),
		.stat    (bstat)
	);

	// step classification and edge tests
	always_comb begin
		acc       = s_tvalid && s_tready;
		in_ok     = ({3'b000, in_start_x} < SIDE_LIM) && ({3'b000, in_start_z} < SIDE_LIM);
		cur_ok    = ({2'b00, bstat.x} < SIDE_LIM) && ({2'b00, bstat.z} < SIDE_LIM);
		walk_end  = bstat.done || !cur_ok;
		out_free  = !m_tvalid_q || m_tready;
		rd_open   = rdata_q[grvc_pkg::FLAG_OPEN];

		mv_x  = bstat.x != lx_q;
		mv_z  = bstat.z != lz_q;
		pos_x = bstat.x > lx_q;
		pos_z = bstat.z > lz_q;
		diag  = mv_x && mv_z;

		// a: cell left closed towards x, b: towards z
		a_hit = pos_x ? cprev_q[grvc_pkg::FLAG_EAST] : cprev_q[grvc_pkg::FLAG_WEST];
		b_hit = pos_z ? cprev_q[grvc_pkg::FLAG_NORTH] : cprev_q[grvc_pkg::FLAG_SOUTH];
		// c: z neighbour open and closed on the same x face
		c_hit = nz_q[grvc_pkg::FLAG_OPEN]
			&& (pos_x ? nz_q[grvc_pkg::FLAG_EAST] : nz_q[grvc_pkg::FLAG_WEST]);
		// d: x neighbour (arriving now) open and closed on the same z face
		d_hit = rdata_q[grvc_pkg::FLAG_OPEN]
			&& (pos_z ? rdata_q[grvc_pkg::FLAG_NORTH] : rdata_q[grvc_pkg::FLAG_SOUTH]);

		straight_blk = (mv_x && !mv_z && a_hit) || (mv_z && !mv_x && b_hit);
		diag_blk     = (a_hit && b_hit) || (a_hit && c_hit) || (b_hit && d_hit)
			|| (c_hit && d_hit);

		cell_vis                       = rdata_q;
		cell_vis[grvc_pkg::FLAG_VIS]   = 1'b1;
		cell_novis                     = rdata_q;
		cell_novis[grvc_pkg::FLAG_VIS] = 1'b0;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			grvc_pkg::ST_INIT_CLR: begin
				if (cnt_q == LAST_ADDR) state_nx = grvc_pkg::ST_IDLE;
			end
			grvc_pkg::ST_IDLE: begin
				if (acc) begin
					case (in_cmd)
						grvc_pkg::CMD_WRITE: state_nx = grvc_pkg::ST_DONE;
						grvc_pkg::CMD_CLEAR: state_nx = grvc_pkg::ST_CLR_FIRST;
						grvc_pkg::CMD_CAST:  state_nx = grvc_pkg::ST_C_CHECK;
						grvc_pkg::CMD_READ: begin
							state_nx = in_ok ? grvc_pkg::ST_RD_WAIT : grvc_pkg::ST_DONE;
						end
						default: state_nx = grvc_pkg::ST_DONE;
					endcase
				end
			end
			grvc_pkg::ST_RD_WAIT:   state_nx = grvc_pkg::ST_DONE;
			grvc_pkg::ST_CLR_FIRST: state_nx = grvc_pkg::ST_CLR_RUN;
			grvc_pkg::ST_CLR_RUN: begin
				if (cnt_q == LAST_ADDR) state_nx = grvc_pkg::ST_CLR_LAST;
			end
			grvc_pkg::ST_CLR_LAST:  state_nx = grvc_pkg::ST_DONE;
			grvc_pkg::ST_C_CHECK: begin
				if (walk_end) begin
					state_nx = grvc_pkg::ST_DONE;
				end else if (diag) begin
					state_nx = grvc_pkg::ST_C_NZ;
				end else if (straight_blk) begin
					state_nx = grvc_pkg::ST_DONE;
				end else begin
					state_nx = grvc_pkg::ST_C_CELL;
				end
			end
			grvc_pkg::ST_C_NZ: state_nx = grvc_pkg::ST_C_NX;
			grvc_pkg::ST_C_NX: begin
				state_nx = diag_blk ? grvc_pkg::ST_DONE : grvc_pkg::ST_C_CELL;
			end
			grvc_pkg::ST_C_CELL: begin
				state_nx = rd_open ? grvc_pkg::ST_C_CHECK : grvc_pkg::ST_DONE;
			end
			grvc_pkg::ST_DONE: begin
				if (out_free) state_nx = grvc_pkg::ST_IDLE;
			end
			default: state_nx = grvc_pkg::ST_INIT_CLR;
		endcase
	end

	// sequencer outputs: memory port, address unit and stepper control
	always_comb begin
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		r_from_cnt   = 1'b0;
		w_from_cnt   = 1'b0;
		w_from_wr    = 1'b0;
		wdata        = rdata_q;
		ax           = bstat.x;
		az           = bstat.z;
		bctl.load    = 1'b0;
		bctl.advance = 1'b0;
		s_tready     = 1'b0;
		case (state_q)
			grvc_pkg::ST_INIT_CLR: begin
				wr_en      = 1'b1;
				w_from_cnt = 1'b1;
				wdata      = '0;
			end
			grvc_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				ax        = {1'b0, in_start_x};
				az        = {1'b0, in_start_z};
				bctl.load = acc && (in_cmd == grvc_pkg::CMD_CAST);
				wr_en     = acc && in_ok && (in_cmd == grvc_pkg::CMD_WRITE);
				rd_en     = acc && in_ok && (in_cmd == grvc_pkg::CMD_READ);
				wdata     = in_wflags;
			end
			grvc_pkg::ST_CLR_FIRST: begin
				rd_en      = 1'b1;
				r_from_cnt = 1'b1;
			end
			grvc_pkg::ST_CLR_RUN: begin
				rd_en      = 1'b1;
				r_from_cnt = 1'b1;
				wr_en      = 1'b1;
				w_from_wr  = 1'b1;
				wdata      = cell_novis;
			end
			grvc_pkg::ST_CLR_LAST: begin
				wr_en     = 1'b1;
				w_from_wr = 1'b1;
				wdata     = cell_novis;
			end
			grvc_pkg::ST_C_CHECK: begin
				// diagonal: fetch the z neighbour (last column, new row) first;
				// both neighbours lie in the grid since both corners do
				if (!walk_end) begin
					if (diag) begin
						ax    = lx_q;
						rd_en = 1'b1;
					end else begin
						rd_en = !straight_blk;
					end
				end
			end
			grvc_pkg::ST_C_NZ: begin
				az    = lz_q;
				rd_en = 1'b1;
			end
			grvc_pkg::ST_C_NX: begin
				rd_en = !diag_blk;
			end
			grvc_pkg::ST_C_CELL: begin
				wr_en        = 1'b1;
				wdata        = rd_open ? cell_vis : cell_novis;
				bctl.advance = rd_open;
			end
			grvc_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// shared address unit
	assign addr_full  = (17'(az) * SIDE_MUL) + 17'(ax);
	assign coord_addr = addr_full[AW-1:0];
	assign raddr      = r_from_cnt ? cnt_q : coord_addr;
	assign waddr      = w_from_cnt ? cnt_q : (w_from_wr ? wr_q : coord_addr);

	// grid memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// result word
	always_comb begin
		case (cmd_q)
			grvc_pkg::CMD_READ: res_data = {18'd0, rd_q};
			grvc_pkg::CMD_CAST: res_data = {5'd0, lz_q[5:0], lx_q[5:0], blk_q, 6'd0};
			default:            res_data = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= grvc_pkg::ST_INIT_CLR;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				grvc_pkg::ST_INIT_CLR:  cnt_q <= cnt_q + AW'(1);
				grvc_pkg::ST_IDLE:      cnt_q <= '0;
				grvc_pkg::ST_CLR_FIRST: cnt_q <= cnt_q + AW'(1);
				grvc_pkg::ST_CLR_RUN: begin
					if (cnt_q != LAST_ADDR) cnt_q <= cnt_q + AW'(1);
				end
				default: begin
				end
			endcase
			if (state_q == grvc_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ray and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			grvc_pkg::ST_IDLE: begin
				if (acc) begin
					cmd_q <= in_cmd;
					lx_q  <= {1'b0, in_start_x};
					lz_q  <= {1'b0, in_start_z};
					blk_q <= 1'b0;
					rd_q  <= '0;
				end
			end
			grvc_pkg::ST_RD_WAIT:   rd_q <= rdata_q;
			grvc_pkg::ST_CLR_FIRST: wr_q <= cnt_q;
			grvc_pkg::ST_CLR_RUN:   wr_q <= cnt_q;
			grvc_pkg::ST_C_CHECK: begin
				if (!walk_end && !diag && straight_blk) blk_q <= 1'b1;
			end
			grvc_pkg::ST_C_NZ: nz_q <= rdata_q;
			grvc_pkg::ST_C_NX: begin
				if (diag_blk) blk_q <= 1'b1;
			end
			grvc_pkg::ST_C_CELL: begin
				if (rd_open) begin
					lx_q    <= bstat.x;
					lz_q    <= bstat.z;
					cprev_q <= rdata_q;
				end else begin
					// closed cell stops the ray
					blk_q <= 1'b1;
				end
			end
			grvc_pkg::ST_DONE: begin
				if (out_free) m_tdata_q <= res_data;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[design/grvc_checker.sv]
// port-level checker for the grid ray visibility caster, with its bind
module grvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: never ready right after taking one
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready straight after a request");

	// a blocked cast never carries read flags
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tdata[5:0] == 6'd0)
		else $error("blocked cast with read flags");

	// padding bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:19] == 5'd0)
		else $error("result padding not zero");

endmodule

bind grid_ray_visibility_cast_unit grvc_checker u_grvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
